/* src/slcg_pkg.sv */
`default_nettype none

package slcg_pkg;

    // field widths
    localparam int VALUE_W = 31;
    localparam int FRAC_W  = 24;

    // multiplicative congruential generator, modulus 2^31-1
    localparam int                 MULT_W   = 15;
    localparam logic [MULT_W-1:0]  LCG_MULT = 15'd16807;
    localparam logic [VALUE_W-1:0] LCG_MOD  = 31'h7fff_ffff;
    localparam int                 PROD_W   = VALUE_W + MULT_W;

    // shuffle table, size is a power of two
    localparam int TABLE_SIZE   = 32;
    localparam int IDX_W        = $clog2(TABLE_SIZE);
    localparam int WARMUP_STEPS = 8;
    localparam int SEED_STEPS   = TABLE_SIZE + WARMUP_STEPS;
    localparam int CNT_W        = $clog2(SEED_STEPS);
    localparam longint SLOT_DIV = 64'd1 + (64'd2147483646 / TABLE_SIZE);
    localparam int SLOT_SHIFT   = $clog2(SLOT_DIV);

    // 1 - 1.2e-7 in 0.24, truncated
    localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777213;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [FRAC_W-1:0]  t_frac;

endpackage

`default_nettype wire

/* src/slcg_in_if.sv */
`default_nettype none

interface slcg_in_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink   (input valid, input reseed, output ready);
endinterface

`default_nettype wire

/* src/slcg_out_if.sv */
`default_nettype none

interface slcg_out_if;
    import slcg_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;
    t_frac  fraction;

    modport source (output valid, output value, output fraction, input ready);
    modport sink   (input valid, input value, input fraction, output ready);
endinterface

`default_nettype wire

/* src/shuffled_lcg_random_generator_core.sv */
// plain draw: the input transaction is followed by ST_MUL, ST_RED and ST_WR; ST_WR waits
//   while an older result is pending; a new request is taken only back in ST_IDLE
// seeding draw (reseed set, or first draw after reset): 40 generator steps come first
// the shared 31x15 multiplier and its mod 2^31-1 reduction make up each generator step
// reset (synchronous, active low) clears the sequencer, the output valid and the last
//   output, sets the seed register to 1; the shuffle table is filled by the first seeding
`default_nettype none

module shuffled_lcg_random_generator_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_wr_en,
    input  wire slcg_pkg::t_value i_cfg_wr_data,
    slcg_in_if.sink              i_in,
    slcg_out_if.source           o_out
);
    import slcg_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_RED  = 4'b0100,
        ST_WR   = 4'b1000
    } t_state;

    t_state              r_state,     n_state;
    t_value              r_seed,      n_seed;
    t_value              r_s,         n_s;       // generator state
    logic [PROD_W-1:0]   r_prod,      n_prod;    // registered product
    t_value              r_last,      n_last;    // last shuffled output, 0 = unseeded
    logic [CNT_W-1:0]    r_cnt,       n_cnt;     // seeding steps left after the current one
    logic                r_seeding,   n_seeding;
    logic                r_out_valid, n_out_valid;
    t_value              r_out_value, n_out_value;
    t_frac               r_out_frac,  n_out_frac;

    // shared reduction: p = hi*2^31 + lo = hi + lo (mod 2^31-1)
    logic [VALUE_W:0]    w_red_sum;
    t_value              w_red;

    // table slot from last output
    t_value              w_slot_raw;
    logic [IDX_W-1:0]    w_slot;

    // table memory ports
    logic                w_wr_en;
    logic [IDX_W-1:0]    w_wr_addr;
    t_value              w_wr_data;
    logic                w_rd_en;
    t_value              w_rd_data;

    // fraction = floor(v * 2^24 / (2^31-1)) using the mersenne form
    logic [FRAC_W-1:0]   w_q0;
    logic [VALUE_W:0]    w_fsum;
    logic [FRAC_W:0]     w_q;
    t_frac               w_frac;

    // seed fixup: zero and the modulus itself both become one
    t_value              w_seed_fix;

    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_wr_go;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = r_out_valid && o_out.ready;
    // draw finish stalls while an older result is still pending
    assign w_wr_go   = !r_out_valid || o_out.ready;

    assign w_seed_fix = (r_seed == '0 || r_seed == LCG_MOD) ? t_value'(1) : r_seed;

    assign w_red_sum = {1'b0, r_prod[VALUE_W-1:0]} + (VALUE_W+1)'(r_prod[PROD_W-1:VALUE_W]);
    assign w_red     = (w_red_sum >= {1'b0, LCG_MOD})
                     ? VALUE_W'(w_red_sum - {1'b0, LCG_MOD})
                     : w_red_sum[VALUE_W-1:0];

    assign w_slot_raw = r_last >> SLOT_SHIFT;
    assign w_slot     = (w_slot_raw >= t_value'(TABLE_SIZE))
                      ? IDX_W'(TABLE_SIZE - 1) : w_slot_raw[IDX_W-1:0];

    assign w_q0   = w_rd_data[VALUE_W-1:VALUE_W-FRAC_W];
    assign w_fsum = {1'b0, w_rd_data[VALUE_W-FRAC_W-1:0], {FRAC_W{1'b0}}}
                  + (VALUE_W+1)'(w_q0);
    assign w_q    = {1'b0, w_q0} + (FRAC_W+1)'(w_fsum >= {1'b0, LCG_MOD});
    assign w_frac = (w_q > {1'b0, FRAC_MAX}) ? FRAC_MAX : w_q[FRAC_W-1:0];

    // memory: seeding writes count down from the last slot, draws read then write one slot
    // seeding stores the freshly reduced step, a draw stores the already stepped state
    always_comb begin
        w_rd_en   = (r_state == ST_RED) && !r_seeding;
        w_wr_en   = 1'b0;
        w_wr_addr = w_slot;
        w_wr_data = r_s;
        if (r_state == ST_RED && r_seeding && r_cnt < CNT_W'(TABLE_SIZE)) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_cnt[IDX_W-1:0];
            w_wr_data = w_red;
        end else if (r_state == ST_WR && w_wr_go) begin
            w_wr_en   = 1'b1;
        end
    end

    slcg_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_slot),
        .o_rd_data (w_rd_data)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_seed      = i_cfg_wr_en ? i_cfg_wr_data : r_seed;
        n_s         = r_s;
        n_prod      = r_prod;
        n_last      = r_last;
        n_cnt       = r_cnt;
        n_seeding   = r_seeding;
        n_out_valid = r_out_valid && !w_out_acc;
        n_out_value = r_out_value;
        n_out_frac  = r_out_frac;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_MUL;
                    if (i_in.reseed || r_last == '0) begin
                        n_s       = w_seed_fix;
                        n_cnt     = CNT_W'(SEED_STEPS - 1);
                        n_seeding = 1'b1;
                    end else begin
                        n_seeding = 1'b0;
                    end
                end
            end
            ST_MUL: begin
                n_prod  = PROD_W'(r_s) * PROD_W'(LCG_MULT);
                n_state = ST_RED;
            end
            ST_RED: begin
                n_s = w_red;
                if (r_seeding) begin
                    n_state = ST_MUL;
                    if (r_cnt == '0) begin
                        // final seeding step also becomes the last output
                        n_last    = w_red;
                        n_seeding = 1'b0;
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end else begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                if (w_wr_go) begin
                    n_last      = w_rd_data;
                    n_out_valid = 1'b1;
                    n_out_value = w_rd_data;
                    n_out_frac  = w_frac;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= t_value'(1);
            r_last      <= '0;
            r_seeding   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed      <= n_seed;
            r_last      <= n_last;
            r_seeding   <= n_seeding;
            r_out_valid <= n_out_valid;
        end
        r_s         <= n_s;
        r_prod      <= n_prod;
        r_cnt       <= n_cnt;
        r_out_value <= n_out_value;
        r_out_frac  <= n_out_frac;
    end

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.value    = r_out_value;
    assign o_out.fraction = r_out_frac;

    // generator state entering the multiplier is never zero or the modulus
    a_state_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL |-> (r_s != '0 && r_s != LCG_MOD))
        else $error("generator state degenerate");

    // a draw only finishes once the generator has been seeded
    a_draw_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WR |-> (r_last != '0 && !r_seeding))
        else $error("draw without seeded table");

    // a finished result is a valid generator value with a clamped fraction
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_value != '0 && r_out_value != LCG_MOD
                         && r_out_frac <= FRAC_MAX))
        else $error("result out of range");

    // a pending result is never overwritten before its transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_value))
        else $error("pending result lost");

    // seeding always starts the full seeding step count, table fill plus warm-up
    a_seed_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_seeding) |-> r_cnt == CNT_W'(SEED_STEPS - 1))
        else $error("seeding count wrong");

endmodule

`default_nettype wire

/* src/slcg_ram.sv */
`default_nettype none

module slcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* tb/shuffled_lcg_random_generator_core_test.sv */
`default_nettype none

module shuffled_lcg_random_generator_core_test;
    import slcg_pkg::*;

    // one expected draw
    typedef struct {
        t_value value;
        t_frac  fraction;
    } t_draw;

    // predicts the shuffled generator and keeps the draws still owed by the block
    class t_draw_scoreboard;
        t_value seed_reg;
        t_value gen_state;
        t_value last_draw;
        t_value shuffle [TABLE_SIZE];
        t_draw  owed_q [$];
        int     errors;
        int     checked;
        int     seedings;
        int     seed_writes;

        function new();
            seed_reg    = 31'd1;
            gen_state   = '0;
            last_draw   = '0;
            errors      = 0;
            checked     = 0;
            seedings    = 0;
            seed_writes = 0;
            foreach (shuffle[i]) shuffle[i] = '0;
        endfunction

        function void write_seed(t_value v);
            seed_reg = v;
            seed_writes++;
        endfunction

        // one step of the minimal standard generator, x * 16807 mod 2^31-1
        function t_value gen_step(t_value s);
            longint unsigned prod;
            prod = 64'(s) * 64'(LCG_MULT);
            return t_value'(prod % 64'(LCG_MOD));
        endfunction

        // reload from the seed register, fill the table back to front after warmup
        function void reseed_table();
            t_value s;
            s = t_value'(64'(seed_reg) % 64'(LCG_MOD));
            if (s == '0) begin
                s = 31'd1;
            end
            for (int n = SEED_STEPS - 1; n >= 0; n--) begin
                s = gen_step(s);
                if (n < TABLE_SIZE) begin
                    shuffle[n] = s;
                end
            end
            gen_state = s;
            last_draw = shuffle[0];
            seedings++;
        endfunction

        function void note_draw(logic reseed);
            longint unsigned slot;
            longint unsigned frac;
            t_draw d;
            if (reseed || last_draw == '0) begin
                reseed_table();
            end
            gen_state = gen_step(gen_state);
            slot = 64'(last_draw) / 64'(SLOT_DIV);
            if (slot >= 64'(TABLE_SIZE)) begin
                slot = 64'(TABLE_SIZE - 1);
            end
            last_draw = shuffle[slot];
            shuffle[slot] = gen_state;
            frac = (64'(last_draw) << FRAC_W) / 64'(LCG_MOD);
            if (frac > 64'(FRAC_MAX)) begin
                frac = 64'(FRAC_MAX);
            end
            d.value    = last_draw;
            d.fraction = t_frac'(frac);
            owed_q.push_back(d);
        endfunction

        function void check_draw(t_value v, t_frac f);
            t_draw d;
            if (owed_q.size() == 0) begin
                $display("%0t unexpected draw: expected none actual value %0d fraction %0d",
                         $time, v, f);
                errors++;
                return;
            end
            d = owed_q.pop_front();
            checked++;
            if (v !== d.value) begin
                $display("%0t value mismatch: expected %0d actual %0d", $time, d.value, v);
                errors++;
            end
            if (f !== d.fraction) begin
                $display("%0t fraction mismatch: expected %0d actual %0d",
                         $time, d.fraction, f);
                errors++;
            end
        endfunction

        function int owed();
            return owed_q.size();
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_wr_en;
    t_value i_cfg_wr_data;

    slcg_in_if  in_if ();
    slcg_out_if out_if ();

    t_draw_scoreboard sb = new();

    // percent chance per cycle of a sender gap / receiver stall
    int idle_pct  = 0;
    int stall_pct = 0;
    // long receiver hold-off, counted down by the receiver
    int hold_left = 0;

    always #2 i_clk = ~i_clk;

    shuffled_lcg_random_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    // offer one draw request, with random gaps ahead of it; returns at the
    // edge that accepted the transaction, valid left high for a back-to-back follow-up
    task automatic send_draw(input logic reseed);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.reseed <= reseed;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        sb.note_draw(reseed);
    endtask

    // drop valid and let every owed draw come back before touching the seed
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.owed() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // seed register write, only while the block is idle
    task automatic write_seed(input t_value v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.write_seed(v);
    endtask

    // a stretch of random draws: the first reloads the new seed, a few others reseed
    task automatic draw_burst(input int count);
        send_draw(1'b1);
        for (int k = 1; k < count; k++) begin
            send_draw($urandom_range(0, 99) < 4);
        end
    endtask

    // receiver: checks each accepted result transaction, then picks next cycle's ready
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                sb.check_draw(out_if.value, out_if.fraction);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // run limit
    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        in_if.valid   <= 1'b0;
        in_if.reseed  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first draw without reseed still seeds, from the reset seed of 1
        send_draw(1'b0);
        send_draw(1'b0);
        send_draw(1'b0);
        send_draw(1'b1);
        send_draw(1'b0);
        drain();

        // zero seed behaves like seed 1
        write_seed('0);
        send_draw(1'b1);
        send_draw(1'b0);
        drain();

        // seed equal to the modulus wraps to zero, then to 1
        write_seed(31'h7fff_ffff);
        send_draw(1'b1);
        send_draw(1'b0);
        drain();

        // largest legal seed
        write_seed(31'd2147483646);
        send_draw(1'b1);
        send_draw(1'b0);
        send_draw(1'b0);
        drain();

        // alternating bit patterns, and reseed twice in a row
        write_seed(31'h2aaa_aaaa);
        send_draw(1'b1);
        send_draw(1'b1);
        send_draw(1'b0);
        drain();
        write_seed(31'h5555_5555);
        send_draw(1'b1);
        send_draw(1'b0);
        drain();

        // random phases, each with its own seed and idling pattern
        write_seed(t_value'($urandom & 32'h7fff_ffff));
        draw_burst(320);
        drain();

        idle_pct = 86;
        write_seed(t_value'($urandom & 32'h7fff_ffff));
        draw_burst(300);
        drain();

        idle_pct  = 0;
        stall_pct = 86;
        write_seed(t_value'($urandom & 32'h7fff_ffff));
        draw_burst(300);
        drain();

        idle_pct  = 17;
        stall_pct = 17;
        write_seed(31'd1);
        draw_burst(300);
        drain();

        // back pressure: receiver holds off for a long stretch while requests keep coming
        idle_pct  = 0;
        stall_pct = 0;
        write_seed(t_value'($urandom & 32'h7fff_ffff));
        hold_left = 300;
        draw_burst(80);
        drain();

        repeat (100) @(posedge i_clk);
        $display("checked %0d draws, %0d of them after a table refill, over %0d seed writes",
                 sb.checked, sb.seedings, sb.seed_writes);
        $display("idling covered none, sender gaps, receiver stalls, both, long hold-off");
        if (sb.errors == 0 && sb.owed() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
src/slcg_pkg.sv
src/slcg_in_if.sv
src/slcg_out_if.sv
src/slcg_ram.sv
src/shuffled_lcg_random_generator_core.sv
tb/shuffled_lcg_random_generator_core_test.sv
